// File: rtl/core/carmichael_number_test_defines.svh
// Assertion macros used by the checker file
`ifndef CARMICHAEL_NUMBER_TEST_DEFINES_SVH
`define CARMICHAEL_NUMBER_TEST_DEFINES_SVH
// Implication checked at every rising clock edge, disabled in reset
`define CNT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication
`define CNT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: rtl/core/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types for the Carmichael number test.
// ----------------------------------------------------------------------------
package cmt_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV1,
        ST_DIV1_W,
        ST_DIV2,
        ST_DIV2_W,
        ST_DIV3,
        ST_DIV3_W,
        ST_TAIL,
        ST_TAIL_W,
        ST_DONE
    } state_t;

    // divider control
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic done;
    } div_sts_t;

endpackage

// File: rtl/core/carmichael_number_test.sv
// ----------------------------------------------------------------------------
// carmichael_number_test
// Carmichael test by trial division and Korselt's criterion.
// ----------------------------------------------------------------------------
// One candidate at a time. Trial divisors d run from 2 while d*d <= m; each
// step costs up to three bit-serial divisions plus control states, and one
// division follows for the cofactor left over. Run time grows with the
// square root of the candidate and is set by the shared serial divider. The
// result sits in an output register; a new candidate is taken once that
// result has been transferred.
module carmichael_number_test #(
    parameter int CAND_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CAND_BITS-1:0] candidate,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 is_carmichael
);

    localparam int W = CAND_BITS;

    cmt_pkg::state_t state_reg, state_next;
    logic [W-1:0]   n_reg, n_next;
    logic [W-1:0]   m_reg, m_next;
    logic [W-1:0]   d_reg, d_next;
    logic [1:0]     fac_reg, fac_next;
    logic           res_reg, res_next;
    logic           ov_reg, ov_next;
    logic [2*W-1:0] sq_reg, sq_next;
    logic [W-1:0]   mq_reg, mq_next;

    cmt_pkg::div_ctl_t dctl;
    cmt_pkg::div_sts_t dsts;
    logic [W-1:0]      dvd, dvs, quo, rem;

    cmt_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
        .sts(dsts), .quotient(quo), .remainder(rem)
    );

    assign in_ready      = (state_reg == cmt_pkg::ST_IDLE) && !ov_reg;
    assign out_valid     = ov_reg;
    assign is_carmichael = res_reg;

    // sequence trial division
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        fac_next   = fac_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        sq_next    = sq_reg;
        mq_next    = mq_reg;
        dctl.start = 1'b0;
        dvd        = m_reg;
        dvs        = d_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            cmt_pkg::ST_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    n_next     = candidate;
                    m_next     = candidate;
                    d_next     = W'(2);
                    fac_next   = '0;
                    state_next = cmt_pkg::ST_MUL;
                    if (candidate < W'(3))
                    begin
                        res_next   = 1'b0;
                        state_next = cmt_pkg::ST_DONE;
                    end
                end
            end
            cmt_pkg::ST_MUL:
            begin
                sq_next    = {{W{1'b0}}, d_reg} * {{W{1'b0}}, d_reg};
                state_next = cmt_pkg::ST_CHECK;
            end
            cmt_pkg::ST_CHECK:
            begin
                if (sq_reg <= {{W{1'b0}}, m_reg})
                begin
                    dctl.start = 1'b1;
                    state_next = cmt_pkg::ST_DIV1;
                end
                else if (m_reg > W'(1))
                begin
                    dvd        = n_reg - W'(1);
                    dvs        = m_reg - W'(1);
                    dctl.start = 1'b1;
                    state_next = cmt_pkg::ST_TAIL;
                end
                else
                begin
                    res_next   = (fac_reg >= 2'd2);
                    state_next = cmt_pkg::ST_DONE;
                end
            end
            cmt_pkg::ST_DIV1: state_next = cmt_pkg::ST_DIV1_W;
            cmt_pkg::ST_DIV1_W:
            begin
                if (dsts.done)
                begin
                    if (rem == '0)
                    begin
                        mq_next    = quo;
                        state_next = cmt_pkg::ST_DIV2;
                    end
                    else
                    begin
                        d_next     = d_reg + W'(1);
                        state_next = cmt_pkg::ST_MUL;
                    end
                end
            end
            cmt_pkg::ST_DIV2:
            begin
                m_next     = mq_reg;
                dvd        = mq_reg;
                dctl.start = 1'b1;
                state_next = cmt_pkg::ST_DIV2_W;
            end
            cmt_pkg::ST_DIV2_W:
            begin
                if (dsts.done)
                begin
                    if (rem == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = cmt_pkg::ST_DONE;
                    end
                    else
                        state_next = cmt_pkg::ST_DIV3;
                end
            end
            cmt_pkg::ST_DIV3:
            begin
                dvd        = n_reg - W'(1);
                dvs        = d_reg - W'(1);
                dctl.start = 1'b1;
                state_next = cmt_pkg::ST_DIV3_W;
            end
            cmt_pkg::ST_DIV3_W:
            begin
                if (dsts.done)
                begin
                    if (rem != '0)
                    begin
                        res_next   = 1'b0;
                        state_next = cmt_pkg::ST_DONE;
                    end
                    else
                    begin
                        if (fac_reg != 2'd3)
                            fac_next = fac_reg + 2'd1;
                        d_next     = d_reg + W'(1);
                        state_next = cmt_pkg::ST_MUL;
                    end
                end
            end
            cmt_pkg::ST_TAIL: state_next = cmt_pkg::ST_TAIL_W;
            cmt_pkg::ST_TAIL_W:
            begin
                if (dsts.done)
                begin
                    res_next   = (rem == '0) && (fac_reg != 2'd0);
                    state_next = cmt_pkg::ST_DONE;
                end
            end
            cmt_pkg::ST_DONE:
            begin
                ov_next    = 1'b1;
                state_next = cmt_pkg::ST_IDLE;
            end
            default: state_next = cmt_pkg::ST_IDLE;
        endcase
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmt_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // hold datapath
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        m_reg   <= m_next;
        d_reg   <= d_next;
        fac_reg <= fac_next;
        res_reg <= res_next;
        sq_reg  <= sq_next;
        mq_reg  <= mq_next;
    end

endmodule

// File: rtl/core/cmt_divider.sv
// ----------------------------------------------------------------------------
// cmt_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmt_divider #(
    parameter int W = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmt_pkg::div_ctl_t ctl,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    output cmt_pkg::div_sts_t sts,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // load operands on start, else shift one dividend bit into the partial remainder
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[W-1]};
        if (ctl.start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // hold iteration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign sts.done  = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

// File: rtl/core/cmt_checker.sv
// ----------------------------------------------------------------------------
// cmt_checker
// Port-level checks on the Carmichael number test.
// ----------------------------------------------------------------------------
`include "carmichael_number_test_defines.svh"

module cmt_checker #(
    parameter int CAND_BITS = 24
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [CAND_BITS-1:0] candidate,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 is_carmichael
);

    `CNT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(is_carmichael), "result dropped while stalled")
    `CNT_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, !in_ready, "input open while result pending")
    `CNT_ASSERT_NXT(a_take_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid, "second transfer during work")
    `CNT_ASSERT_IMP(a_small, clk, rst_n, in_valid && in_ready && candidate < CAND_BITS'(3), 1'b1 ##2 (out_valid && !is_carmichael), "small value flagged")

endmodule

bind carmichael_number_test cmt_checker #(.CAND_BITS(CAND_BITS)) u_cmt_checker (.*);

// File: test/tb_carmichael_number_test.sv
// ----------------------------------------------------------------------------
// tb_carmichael_number_test
// Self-checking bench for the Carmichael number test.
// ----------------------------------------------------------------------------
// Candidates go in over a valid/ready channel with random gaps. Each one is
// classified here by Korselt's criterion and the verdict is queued. Every
// result transfer is compared against the oldest queued verdict. Most
// candidates are small because run time grows with the square root of the
// candidate; only a handful reach the top of the range.
// ----------------------------------------------------------------------------
module tb_carmichael_number_test;

    localparam int CAND_BITS = 24;
    localparam int MAX_GAP   = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CAND_BITS-1:0] candidate;
    logic                 out_valid;
    logic                 out_ready;
    logic                 is_carmichael;

    bit   verdict_q[$];
    bit   failed;
    bit   quiet;
    int   outstanding;

    carmichael_number_test #(
        .CAND_BITS(CAND_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .candidate    (candidate),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_carmichael(is_carmichael)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Classify by Korselt: squarefree, at least two primes, p-1 divides n-1
    function automatic bit korselt(input logic [CAND_BITS-1:0] value);
        longint unsigned n;
        longint unsigned m;
        longint unsigned d;
        int              primes;
        n = 64'(value);
        m = n;
        primes = 0;
        if (n < 3)
            return 1'b0;
        for (d = 2; d * d <= m; d++)
        begin
            if (m % d == 0)
            begin
                m = m / d;
                if (m % d == 0)
                    return 1'b0;
                if ((n - 1) % (d - 1) != 0)
                    return 1'b0;
                primes++;
            end
        end
        if (m > 1)
        begin
            if ((n - 1) % (m - 1) != 0)
                return 1'b0;
            primes++;
        end
        return primes >= 2;
    endfunction

    // Send one candidate and queue its verdict on transfer
    task automatic send_candidate(input int unsigned value);
        int gap;
        in_valid  <= 1'b1;
        candidate <= CAND_BITS'(value);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict_q.push_back(korselt(CAND_BITS'(value)));
        outstanding++;
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, MAX_GAP);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the result side in random bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result transfer with the oldest verdict
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0b",
                         $time, is_carmichael);
                failed = 1'b1;
            end
            else
            begin
                bit want;
                want = verdict_q.pop_front();
                outstanding--;
                if (is_carmichael !== want)
                begin
                    $display("%0t: is_carmichael mismatch, expected %0b, actual %0b",
                             $time, want, is_carmichael);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic test_small_values();
        send_candidate(0);
        send_candidate(1);
        send_candidate(2);
        send_candidate(3);
        send_candidate(4);
    endtask

    task automatic test_known_carmichael();
        send_candidate(561);
        send_candidate(1105);
        send_candidate(1729);
        send_candidate(2465);
        send_candidate(8911);
        send_candidate(41041);
        send_candidate(62745);
    endtask

    task automatic test_near_misses();
        // squares, prime powers, primes and plain composites
        send_candidate(9);
        send_candidate(49);
        send_candidate(3 * 3 * 11 * 17);
        send_candidate(97);
        send_candidate(1000);
        send_candidate(16777213);
    endtask

    task automatic test_wide_values();
        send_candidate(32'h00FF_FFFF);
        send_candidate(32'h0080_0000);
        send_candidate(32'h00AA_AAAA);
        send_candidate(32'h0055_5554);
    endtask

    task automatic test_random(input int count);
        int unsigned famous[8] = '{561, 1105, 1729, 2465, 2821, 6601, 8911, 10585};
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 4)
                send_candidate(famous[$urandom_range(0, 7)]);
            else if (pick == 4 && i % 25 == 0)
                send_candidate($urandom_range(0, 32'h00FF_FFFF));
            else
                send_candidate($urandom_range(0, 4095));
        end
    endtask

    initial
    begin
        failed      = 1'b0;
        quiet       = 1'b0;
        outstanding = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        candidate   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_values();
        test_known_carmichael();
        test_near_misses();
        test_wide_values();
        test_random(80);
        quiet = 1'b1;
        test_random(20);
        in_valid <= 1'b0;

        // drain
        while (outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // overall time limit
    initial
    begin
        #80000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
